// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Request and result structs, operation and status codes, cell command.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int KEY_BITS          = 32;
    localparam int FIELD_BITS        = 32;
    localparam int PAYLOAD_WIDE_BITS = 64;
    localparam int DEPTH_DEFAULT     = 64;
    localparam int PAYLOAD_DEFAULT   = 32;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic signed [KEY_BITS-1:0] key_t;

    typedef struct packed {
        op_t                   operation;
        key_t                  priority_key;
        logic [FIELD_BITS-1:0] payload;
    } spq_req_t;

    typedef struct packed {
        status_t               status;
        key_t                  out_key;
        logic [FIELD_BITS-1:0] out_payload;
    } spq_rsp_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
        key_t key;
    } spq_cmd_t;

endpackage

// File: hdl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one entry, compares it with the broadcast key and shifts right on an
// insertion or left on a pop.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int PAYLOAD_BITS = PAYLOAD_DEFAULT,
    parameter bit HEAD         = 1'b0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  spq_cmd_t                cmd,
    input  logic [PAYLOAD_BITS-1:0] new_pay,
    input  logic                    left_valid,
    input  logic                    left_move,
    input  key_t                    left_key,
    input  logic [PAYLOAD_BITS-1:0] left_pay,
    input  logic                    right_valid,
    input  key_t                    right_key,
    input  logic [PAYLOAD_BITS-1:0] right_pay,
    output logic                    valid,
    output logic                    move,
    output key_t                    key,
    output logic [PAYLOAD_BITS-1:0] pay
);

    logic                    valid_reg;
    logic                    valid_next;
    key_t                    key_reg;
    key_t                    key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PAYLOAD_BITS-1:0] pay_next;
    logic                    behind;

    // Head yields only to a strictly smaller key; others yield on equal too
    assign behind = HEAD ? (key_reg > cmd.key) : (key_reg >= cmd.key);
    assign move   = !valid_reg || behind;

    // Next contents of the slot
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        if (cmd.push)
        begin
            valid_next = valid_reg | left_valid;
            if (move)
            begin
                if (left_move)
                begin
                    key_next = left_key;
                    pay_next = left_pay;
                end
                else
                begin
                    key_next = cmd.key;
                    pay_next = new_pay;
                end
            end
        end
        else if (cmd.pop)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            pay_next   = right_pay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry data needs no reset: read only while valid
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign pay   = pay_reg;

endmodule

// File: hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Result: the result of a request is presented in the cycle after it is taken.
// Throughput: one push or pop per cycle while no waiting result is stalled;
// every cell compares and shifts in the same cycle, so the row of cells sets no extra wait.
// Reset: asynchronous, active low; empties the queue and drops any pending
// result. Entry storage itself is not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded min-priority queue, sorted by signed key
// A row of DEPTH cells keeps entries in order, head at cell zero; a push
// inserts by compare-and-shift, a pop shifts the row towards the head.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  spq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output spq_rsp_t rsp
);

    logic                    cell_valid [DEPTH];
    logic                    cell_move  [DEPTH];
    key_t                    cell_key   [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_pay   [DEPTH];

    logic                         accept;
    logic                         empty;
    logic                         full;
    spq_cmd_t                     cmd;
    logic [PAYLOAD_WIDE_BITS-1:0] in_pay_wide;
    logic [PAYLOAD_WIDE_BITS-1:0] head_pay_wide;
    logic [PAYLOAD_BITS-1:0]      new_pay;

    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    spq_rsp_t rsp_reg;
    spq_rsp_t rsp_next;

    // Request handshake: a waiting result blocks only while it is stalled
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign empty = !cell_valid[0];
    assign full  = cell_valid[DEPTH-1];

    // Payload kept to PAYLOAD_BITS
    assign in_pay_wide   = PAYLOAD_WIDE_BITS'(req.payload);
    assign new_pay       = in_pay_wide[PAYLOAD_BITS-1:0];
    assign head_pay_wide = PAYLOAD_WIDE_BITS'(cell_pay[0]);

    // Command to the row
    always_comb
    begin
        cmd.push = accept && (req.operation == OP_PUSH) && !full;
        cmd.pop  = accept && (req.operation == OP_POP) && !empty;
        cmd.key  = req.priority_key;
    end

    // Result for this request, taken from the head before it moves
    always_comb
    begin
        rsp_next.status      = ST_OK;
        rsp_next.out_key     = '0;
        rsp_next.out_payload = '0;
        case (req.operation)
            OP_PUSH:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.out_key     = cell_key[0];
                    rsp_next.out_payload = head_pay_wide[FIELD_BITS-1:0];
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Row of cells, head first
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                    left_valid;
        logic                    left_move;
        key_t                    left_key;
        logic [PAYLOAD_BITS-1:0] left_pay;
        logic                    right_valid;
        key_t                    right_key;
        logic [PAYLOAD_BITS-1:0] right_pay;

        if (i == 0)
        begin : g_head
            assign left_valid = 1'b1;
            assign left_move  = 1'b0;
            assign left_key   = '0;
            assign left_pay   = '0;
        end
        else
        begin : g_body
            assign left_valid = cell_valid[i-1];
            assign left_move  = cell_move[i-1];
            assign left_key   = cell_key[i-1];
            assign left_pay   = cell_pay[i-1];
        end

        if (i == DEPTH-1)
        begin : g_tail
            assign right_valid = 1'b0;
            assign right_key   = '0;
            assign right_pay   = '0;
        end
        else
        begin : g_link
            assign right_valid = cell_valid[i+1];
            assign right_key   = cell_key[i+1];
            assign right_pay   = cell_pay[i+1];
        end

        spq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .HEAD         (i == 0)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_pay     (new_pay),
            .left_valid  (left_valid),
            .left_move   (left_move),
            .left_key    (left_key),
            .left_pay    (left_pay),
            .right_valid (right_valid),
            .right_key   (right_key),
            .right_pay   (right_pay),
            .valid       (cell_valid[i]),
            .move        (cell_move[i]),
            .key         (cell_key[i]),
            .pay         (cell_pay[i])
        );
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_priority_queue
// Drives pushes and pops through the request channel, predicts every result
// with a shadow sorted list and compares each result field by field. Random
// gaps on both sides, a long result hold-off, overflow and empty cases.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int PAYLOAD_BITS = PAYLOAD_DEFAULT;
    localparam logic [FIELD_BITS-1:0] PAYLOAD_MASK =
        {FIELD_BITS{1'b1}} >> (FIELD_BITS - PAYLOAD_BITS);
    localparam key_t KEY_MIN = key_t'(32'h8000_0000);
    localparam key_t KEY_MAX = key_t'(32'h7fff_ffff);

    typedef struct packed {
        key_t                  key;
        logic [FIELD_BITS-1:0] handle;
    } entry_t;

    typedef enum int {
        KEYS_FULL,
        KEYS_TIES,
        KEYS_EDGES
    } key_mode_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    spq_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    spq_rsp_t rsp;

    // shadow copy of the queue contents and the results still owed
    entry_t   shadow_list[$];
    spq_rsp_t pending_results[$];

    bit req_idle_en = 1'b1;
    bit rsp_idle_en = 1'b1;
    int hold_cycles = 0;
    int stall_left  = 0;

    int errors     = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_stored   = 0;
    int n_refused  = 0;
    int n_popped   = 0;
    int n_pop_void = 0;

    sorted_priority_queue #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Apply one request to the shadow list and return the result it owes
    function automatic spq_rsp_t apply_request(input spq_req_t r);
        spq_rsp_t res;
        entry_t   ent;
        int       slot;
        res = '{status: ST_OK, out_key: '0, out_payload: '0};
        if (r.operation == OP_PUSH)
        begin
            if (shadow_list.size() >= DEPTH)
            begin
                res.status = ST_FULL;
                n_refused++;
            end
            else
            begin
                ent.key    = r.priority_key;
                ent.handle = r.payload & PAYLOAD_MASK;
                // new head if smaller than the head, else ahead of the first
                // later entry whose key is not smaller
                if (shadow_list.size() == 0 || ent.key < shadow_list[0].key)
                    slot = 0;
                else
                begin
                    slot = 1;
                    while (slot < shadow_list.size() && shadow_list[slot].key < ent.key)
                        slot++;
                end
                shadow_list.insert(slot, ent);
                n_stored++;
            end
        end
        else
        begin
            if (shadow_list.size() == 0)
            begin
                res.status = ST_EMPTY;
                n_pop_void++;
            end
            else
            begin
                ent             = shadow_list.pop_front();
                res.out_key     = ent.key;
                res.out_payload = ent.handle;
                n_popped++;
            end
        end
        return res;
    endfunction

    // Compare one result with the oldest outstanding expectation
    task automatic check_result(input spq_rsp_t got);
        spq_rsp_t want;
        if (pending_results.size() == 0)
        begin
            errors++;
            $error("unexpected result: status %0d key %0d payload %h",
                   got.status, got.out_key, got.out_payload);
        end
        else
        begin
            want = pending_results.pop_front();
            n_checked++;
            if (got.status !== want.status)
            begin
                errors++;
                $error("status: expected %0d, got %0d", want.status, got.status);
            end
            if (got.out_key !== want.out_key)
            begin
                errors++;
                $error("out_key: expected %0d, got %0d", want.out_key, got.out_key);
            end
            if (got.out_payload !== want.out_payload)
            begin
                errors++;
                $error("out_payload: expected %h, got %h",
                       want.out_payload, got.out_payload);
            end
        end
    endtask

    // Monitor: sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (req_valid === 1'b1 && req_stall === 1'b0)
                pending_results.push_back(apply_request(req));
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
                check_result(rsp);
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic key_t pick_key(input key_mode_t mode);
        int r;
        case (mode)
            KEYS_TIES:
                return key_t'(int'($urandom_range(0, 6)) - 3);
            KEYS_EDGES:
            begin
                r = $urandom_range(0, 3);
                case (r)
                    0:       return KEY_MIN + key_t'($urandom_range(0, 2));
                    1:       return KEY_MAX - key_t'($urandom_range(0, 2));
                    2:       return key_t'(int'($urandom_range(0, 2)) - 1);
                    default: return key_t'($urandom);
                endcase
            end
            default:
                return key_t'($urandom);
        endcase
    endfunction

    // Result side: random stalls, plus a counted hold-off on request
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (rsp_idle_en)
                    stall_left = pick_gap();
            end
        end
    end

    // Offer one request, after an optional gap, and wait until it is taken
    task automatic send_request(input op_t op, input key_t key,
                                input logic [FIELD_BITS-1:0] handle);
        int gap;
        gap = req_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= '{operation: op, priority_key: key, payload: handle};
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        n_sent++;
    endtask

    // Sender pauses until every owed result has arrived
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Empty pop, head replacement, ties, key and payload extremes
    task automatic test_directed();
        send_request(OP_POP, KEY_MAX, '1);
        send_request(OP_PUSH, key_t'(0), 32'h0000_0000);
        send_request(OP_PUSH, key_t'(0), 32'h0000_0001);
        send_request(OP_PUSH, KEY_MIN, 32'hffff_ffff);
        send_request(OP_PUSH, KEY_MAX, 32'h5555_5555);
        send_request(OP_PUSH, key_t'(0), 32'h0000_0002);
        send_request(OP_PUSH, key_t'(-1), 32'haaaa_aaaa);
        send_request(OP_PUSH, key_t'(1), 32'h8000_0000);
        send_request(OP_PUSH, KEY_MAX, 32'h7fff_ffff);
        repeat (9) send_request(OP_POP, key_t'(0), '0);
        // equal to head lands behind it
        send_request(OP_PUSH, key_t'(5), 32'h0000_00a0);
        send_request(OP_PUSH, key_t'(5), 32'h0000_00a1);
        send_request(OP_PUSH, key_t'(4), 32'h0000_00a2);
        repeat (4) send_request(OP_POP, KEY_MIN, '1);
        wait_drained();
    endtask

    // Fill to the brim, overflow, then drain past empty
    task automatic test_fill_and_overflow();
        int room;
        room = DEPTH - shadow_list.size();
        repeat (room + 3) send_request(OP_PUSH, pick_key(KEYS_FULL), $urandom);
        repeat (DEPTH + 2) send_request(OP_POP, pick_key(KEYS_FULL), $urandom);
        wait_drained();
    endtask

    // Results held off for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_cycles = 150;
        repeat (24)
            send_request(($urandom_range(0, 3) == 0) ? OP_POP : OP_PUSH,
                         pick_key(KEYS_TIES), $urandom);
        wait_drained();
    endtask

    task automatic test_random_mix(input int count, input int push_pct,
                                   input key_mode_t mode);
        op_t op;
        repeat (count)
        begin
            op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
            send_request(op, pick_key(mode), $urandom);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_and_overflow();
        test_backpressure();
        test_random_mix(250, 50, KEYS_FULL);
        test_random_mix(250, 75, KEYS_TIES);
        wait_drained();
        test_random_mix(200, 30, KEYS_EDGES);
        // a stretch with no idling on either side
        req_idle_en = 1'b0;
        rsp_idle_en = 1'b0;
        test_random_mix(200, 55, KEYS_TIES);
        rsp_idle_en = 1'b1;
        test_random_mix(200, 60, KEYS_FULL);
        req_idle_en = 1'b1;
        test_backpressure();

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests, %0d results checked", n_sent, n_checked);
        $display("  pushes stored %0d, refused full %0d, pops %0d, pops on empty %0d",
                 n_stored, n_refused, n_popped, n_pop_void);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
dv/testbench.sv
